// ===== src/web_pkg.sv =====
`timescale 1ns / 1ps

package web_pkg;

	localparam int BINS      = 64;
	localparam int BIN_W     = $clog2(BINS);
	localparam int CUR_W     = BIN_W + 1;
	localparam int TOTAL_W   = 26;
	localparam int SUM_W     = 36;
	localparam int SAMPLE_W  = 16;
	localparam int MAG_W     = SAMPLE_W + 1;
	localparam int PCT_W     = 7;
	localparam int PCT_MAX   = 100;
	localparam int STEP_W    = $clog2(PCT_W);
	localparam int PROD_W    = SUM_W + PCT_W;
	localparam int BIN_NUM_W = 6;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = QPTR_W + 1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       end_of_recording;
	} in_item_t;

	typedef struct packed {
		logic [BIN_NUM_W-1:0] bin_number;
		logic [PCT_W-1:0]     percent;
		logic                 last_bin;
	} out_item_t;

	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             last;
	} q_item_t;

	typedef struct packed {
		logic    valid;
		q_item_t item;
	} link_t;

	function automatic logic [MAG_W-1:0] magnitude(input logic signed [SAMPLE_W-1:0] s);
		logic [MAG_W-1:0] ext;
		ext = MAG_W'(unsigned'(s));
		if (s[SAMPLE_W-1]) begin
			return (MAG_W'(1) << SAMPLE_W) - ext;
		end
		return ext;
	endfunction

endpackage

// ===== src/web_front.sv =====
`timescale 1ns / 1ps

module web_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  web_pkg::in_item_t sample_item,
	output web_pkg::link_t    link,
	input  logic              link_pop
);

	web_pkg::q_item_t                 entry_q [web_pkg::QDEPTH];
	logic [web_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [web_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [web_pkg::QCNT_W-1:0]       count_q;
	logic                             do_push;
	logic                             do_pop;

	assign full    = count_q == web_pkg::QCNT_W'(web_pkg::QDEPTH);
	assign do_push = push && !full;
	assign do_pop  = link_pop && (count_q != '0);

	assign link.valid = count_q != '0;
	assign link.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// magnitude taken on entry so the back end only adds
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q].mag  <= web_pkg::magnitude(sample_item.sample);
			entry_q[wr_ptr_q].last <= sample_item.end_of_recording;
		end
	end

endmodule

// ===== src/web_back.sv =====
`timescale 1ns / 1ps

module web_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  web_pkg::link_t               link,
	output logic                         link_pop,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [web_pkg::TOTAL_W-1:0]  cfg_data,
	output logic                         empty,
	input  logic                         pop,
	output web_pkg::out_item_t           result
);

	typedef enum logic [2:0] {
		ST_RUN,
		ST_READ,
		ST_MUL,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t                            state_q;
	logic [web_pkg::TOTAL_W-1:0]       width_q;
	logic [web_pkg::CUR_W-1:0]         cur_q;
	logic [web_pkg::TOTAL_W-1:0]       cnt_q;
	logic [web_pkg::SUM_W-1:0]         sum_q;
	logic [web_pkg::SUM_W-1:0]         largest_q;
	logic [web_pkg::BINS-1:0]          valid_q;
	logic [web_pkg::SUM_W-1:0]         mem [web_pkg::BINS];
	logic [web_pkg::SUM_W-1:0]         rd_data_s1;
	logic                              rd_vld_s1;
	logic [web_pkg::BIN_W-1:0]         idx_q;
	logic                              zero_q;
	logic [web_pkg::PROD_W-1:0]        rem_q;
	logic [web_pkg::PROD_W-1:0]        dsh_q;
	logic [web_pkg::PCT_W-1:0]         quo_q;
	logic [web_pkg::STEP_W-1:0]        step_q;
	logic                              out_vld_q;
	web_pkg::out_item_t                out_q;

	logic                              width_nz;
	logic                              adv;
	logic [web_pkg::CUR_W-1:0]         cur_nxt;
	logic [web_pkg::TOTAL_W-1:0]       cnt_base;
	logic [web_pkg::SUM_W-1:0]         sum_base;
	logic                              add;
	logic [web_pkg::SUM_W:0]           sum_ext;
	logic [web_pkg::SUM_W-1:0]         sum_sat;
	logic [web_pkg::SUM_W-1:0]         largest_nxt;
	logic                              take;
	logic                              cfg_wr;
	logic [web_pkg::SUM_W-1:0]         rd_sum;
	logic [web_pkg::PROD_W-1:0]        prod;
	logic                              dge;
	logic                              slot_free;
	logic [web_pkg::PCT_W-1:0]         pct;

	assign width_nz = width_q != '0;
	assign adv      = width_nz && (cnt_q >= width_q)
		&& (cur_q < web_pkg::CUR_W'(web_pkg::BINS));
	assign cur_nxt  = adv ? cur_q + 1'b1 : cur_q;
	assign cnt_base = adv ? '0 : cnt_q;
	assign sum_base = adv ? '0 : sum_q;
	assign add      = width_nz && (cur_nxt < web_pkg::CUR_W'(web_pkg::BINS));
	assign sum_ext  = {1'b0, sum_base} + (web_pkg::SUM_W + 1)'(link.item.mag);
	assign sum_sat  = sum_ext[web_pkg::SUM_W] ? '1 : sum_ext[web_pkg::SUM_W-1:0];
	assign largest_nxt = (add && (sum_sat > largest_q)) ? sum_sat : largest_q;

	assign cfg_ready = state_q == ST_RUN;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign take      = (state_q == ST_RUN) && link.valid && !cfg_valid;
	assign link_pop  = take;

	assign rd_sum = rd_vld_s1 ? rd_data_s1 : '0;
	assign prod   = web_pkg::PROD_W'(rd_sum) * web_pkg::PROD_W'(web_pkg::PCT_MAX);
	assign dge    = rem_q >= dsh_q;

	assign slot_free = !out_vld_q || pop;
	assign pct = zero_q ? '0
		: ((quo_q > web_pkg::PCT_W'(web_pkg::PCT_MAX)) ? web_pkg::PCT_W'(web_pkg::PCT_MAX) : quo_q);

	assign empty  = !out_vld_q;
	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_RUN;
			width_q   <= '0;
			cur_q     <= '0;
			cnt_q     <= '0;
			sum_q     <= '0;
			largest_q <= '0;
			valid_q   <= '0;
			idx_q     <= '0;
			zero_q    <= 1'b0;
			rem_q     <= '0;
			dsh_q     <= '0;
			quo_q     <= '0;
			step_q    <= '0;
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else begin
			if (pop && out_vld_q && (state_q != ST_EMIT)) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_RUN: begin
					if (cfg_wr) begin
						// bin width = total_samples / BINS
						width_q <= cfg_data >> web_pkg::BIN_W;
					end else if (take) begin
						if (width_nz) begin
							cur_q     <= cur_nxt;
							cnt_q     <= add ? cnt_base + 1'b1 : cnt_base;
							sum_q     <= add ? sum_sat : sum_base;
							largest_q <= largest_nxt;
							if (add) begin
								valid_q[cur_nxt[web_pkg::BIN_W-1:0]] <= 1'b1;
							end
						end
						if (link.item.last) begin
							idx_q   <= '0;
							zero_q  <= !width_nz || (largest_nxt == '0);
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					rem_q   <= prod;
					dsh_q   <= web_pkg::PROD_W'(largest_q) << (web_pkg::PCT_W - 1);
					quo_q   <= '0;
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (dge) begin
						rem_q <= rem_q - dsh_q;
					end
					quo_q  <= {quo_q[web_pkg::PCT_W-2:0], dge};
					dsh_q  <= dsh_q >> 1;
					step_q <= step_q + 1'b1;
					if (step_q == web_pkg::STEP_W'(web_pkg::PCT_W - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_vld_q        <= 1'b1;
						out_q.bin_number <= web_pkg::BIN_NUM_W'(idx_q);
						out_q.percent    <= pct;
						out_q.last_bin   <= idx_q == web_pkg::BIN_W'(web_pkg::BINS - 1);
						if (idx_q == web_pkg::BIN_W'(web_pkg::BINS - 1)) begin
							cur_q     <= '0;
							cnt_q     <= '0;
							sum_q     <= '0;
							largest_q <= '0;
							valid_q   <= '0;
							state_q   <= ST_RUN;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// bin sums: running sum written through for each sample added to a bin, read once per bin on readout
	always_ff @(posedge clk) begin
		if (take && add) begin
			mem[cur_nxt[web_pkg::BIN_W-1:0]] <= sum_sat;
		end
		rd_data_s1 <= mem[idx_q];
		rd_vld_s1  <= valid_q[idx_q];
	end

	a_no_pop_in_readout: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) |-> !link_pop)
		else $error("queue popped during readout");

	a_bin_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= web_pkg::CUR_W'(web_pkg::BINS))
		else $error("current bin past end");

	a_percent_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_q.percent <= web_pkg::PCT_W'(web_pkg::PCT_MAX)))
		else $error("percent above full scale");

	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && slot_free && (idx_q == web_pkg::BIN_W'(web_pkg::BINS - 1)))
		|=> ((cur_q == '0) && (largest_q == '0) && (valid_q == '0)))
		else $error("run state not cleared after last bin");

endmodule

// ===== src/waveform_envelope_binner.sv =====
`timescale 1ns / 1ps

// Accumulates the magnitude of each sample into one of BINS bins (bin width is
// total_samples / BINS) and, on the sample marked end_of_recording, reports every
// bin in order as a truncated percentage of the largest bin. While accumulating,
// one sample is taken per cycle when the queue holds one and no configuration write
// is pending; the running sum of the current bin sits in a register and is written
// through to the bin memory, so no read is needed. A four-entry queue decouples
// input from the accumulator. Readout of each bin is a memory read, multiply by 100,
// seven-step restoring divider and emit; input stalls during readout once the queue
// fills. A configuration write sets the bin width to total_samples shifted right by
// log2(BINS); cfg_ready is low only during readout. Bin storage is cleared by
// per-bin valid bits, so there is no clearing pass after reset.
module waveform_envelope_binner (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  web_pkg::in_item_t            sample_item,
	output logic                         empty,
	input  logic                         pop,
	output web_pkg::out_item_t           result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [web_pkg::TOTAL_W-1:0]  cfg_data
);

	web_pkg::link_t link;
	logic           link_pop;

	web_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.sample_item (sample_item),
		.link        (link),
		.link_pop    (link_pop)
	);

	web_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.link      (link),
		.link_pop  (link_pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int ITEM_TARGET = 410;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT = 20000000;
	localparam longint unsigned SUM_LIMIT = (64'd1 << web_pkg::SUM_W) - 1;
	localparam int TOTAL_MAX = (1 << web_pkg::TOTAL_W) - 1;

	typedef enum {ROW_CFG, ROW_SAMPLE} row_kind_t;
	typedef enum {STYLE_ZERO, STYLE_EXTREME, STYLE_QUIET, STYLE_FULL} amp_style_t;

	typedef struct {
		row_kind_t kind;
		int        value;
		bit        eor;
		bit        typed;
		int        pct_first;
		int        pct_rest;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	web_pkg::in_item_t sample_item = '0;
	logic empty;
	logic pop = 1'b0;
	web_pkg::out_item_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [web_pkg::TOTAL_W-1:0] cfg_data = '0;

	longint unsigned pred_total;
	longint unsigned pred_sums [web_pkg::BINS];
	longint unsigned pred_count;
	longint unsigned pred_peak;
	int pred_bin;
	web_pkg::out_item_t report_buf [web_pkg::BINS];
	web_pkg::out_item_t bin_report_q [$];
	stim_row_t directed_rows [$];

	int mismatches = 0;
	int items_sent = 0;
	int send_calm = 0;
	int pop_stall = 0;
	int pop_calm = 0;
	int cycle_count = 0;
	web_pkg::out_item_t want;

	waveform_envelope_binner DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample_item(sample_item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic int pick_total();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(0, web_pkg::BINS - 1);
			2: return TOTAL_MAX;
			3: return $urandom_range(0, TOTAL_MAX);
			default: return web_pkg::BINS * $urandom_range(1, 4)
				+ $urandom_range(0, web_pkg::BINS - 1);
		endcase
	endfunction

	function automatic logic signed [web_pkg::SAMPLE_W-1:0] pick_sample(amp_style_t style);
		case (style)
			STYLE_ZERO: return '0;
			STYLE_EXTREME: begin
				case ($urandom_range(0, 3))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return -16'sd1;
					default: return 16'sd1;
				endcase
			end
			STYLE_QUIET: return web_pkg::SAMPLE_W'($urandom_range(0, 200) - 100);
			default: return web_pkg::SAMPLE_W'($urandom_range(0, 16'hffff));
		endcase
	endfunction

	// envelope accumulation, returns the number of bin reports left in report_buf
	function automatic int envelope_accumulate(web_pkg::in_item_t it);
		longint unsigned width, mag, acc, pct;
		int sv;
		width = pred_total / web_pkg::BINS;
		sv = it.sample;
		mag = (sv < 0) ? -sv : sv;
		if (width != 0) begin
			if (pred_count >= width && pred_bin < web_pkg::BINS) begin
				pred_bin++;
				pred_count = 0;
			end
			if (pred_bin < web_pkg::BINS) begin
				acc = pred_sums[pred_bin] + mag;
				if (acc > SUM_LIMIT) acc = SUM_LIMIT;
				pred_sums[pred_bin] = acc;
				if (acc > pred_peak) pred_peak = acc;
				pred_count++;
			end
		end
		if (!it.end_of_recording) return 0;
		for (int b = 0; b < web_pkg::BINS; b++) begin
			pct = 0;
			if (width != 0 && pred_peak != 0)
				pct = (pred_sums[b] * web_pkg::PCT_MAX) / pred_peak;
			if (pct > web_pkg::PCT_MAX) pct = web_pkg::PCT_MAX;
			report_buf[b].bin_number = web_pkg::BIN_NUM_W'(b);
			report_buf[b].percent = web_pkg::PCT_W'(pct);
			report_buf[b].last_bin = (b == web_pkg::BINS - 1);
		end
		foreach (pred_sums[b]) pred_sums[b] = 0;
		pred_bin = 0;
		pred_count = 0;
		pred_peak = 0;
		return web_pkg::BINS;
	endfunction

	task automatic add_row(row_kind_t kind, int value, bit eor = 1'b0, bit typed = 1'b0,
			int pct_first = 0, int pct_rest = 0);
		stim_row_t row;
		row.kind = kind;
		row.value = value;
		row.eor = eor;
		row.typed = typed;
		row.pct_first = pct_first;
		row.pct_rest = pct_rest;
		directed_rows.push_back(row);
	endtask

	task automatic write_total(int value);
		push <= 1'b0;
		wait (bin_report_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= web_pkg::TOTAL_W'(value);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		pred_total = web_pkg::TOTAL_W'(value);
	endtask

	task automatic send_sample(web_pkg::in_item_t it, bit typed = 1'b0, int pct_first = 0,
			int pct_rest = 0);
		int gap, n;
		web_pkg::out_item_t e;
		if (send_calm > 0) begin
			send_calm--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 99) == 0) send_calm = $urandom_range(30, 150);
			gap = pick_gap();
		end
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		sample_item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		n = envelope_accumulate(it);
		for (int b = 0; b < n; b++) begin
			e = report_buf[b];
			if (typed) e.percent = web_pkg::PCT_W'((b == 0) ? pct_first : pct_rest);
			bin_report_q.push_back(e);
		end
		items_sent++;
	endtask

	task automatic report_mismatch(string what, web_pkg::out_item_t exp_item,
			web_pkg::out_item_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected bin %0d pct %0d last %0b, got bin %0d pct %0d last %0b",
				$time, what, exp_item.bin_number, exp_item.percent, exp_item.last_bin,
				got.bin_number, got.percent, got.last_bin);
	endtask

	// result side: random stalls with calm stretches
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_stall > 0) begin
			pop <= 1'b0;
			pop_stall--;
		end else begin
			pop <= 1'b1;
			if (pop_calm > 0) begin
				pop_calm--;
			end else if ($urandom_range(0, 199) == 0) begin
				pop_calm = $urandom_range(50, 300);
			end else if ($urandom_range(0, 3) == 0) begin
				pop_stall = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (bin_report_q.size() == 0) begin
				report_mismatch("unexpected bin report", '0, result);
			end else begin
				want = bin_report_q.pop_front();
				if (result.bin_number !== want.bin_number || result.percent !== want.percent ||
						result.last_bin !== want.last_bin)
					report_mismatch("bin report mismatch", want, result);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		web_pkg::in_item_t it;
		int len, r;
		amp_style_t style;
		pred_total = 0;
		foreach (pred_sums[b]) pred_sums[b] = 0;
		pred_bin = 0;
		pred_count = 0;
		pred_peak = 0;

		// zero width after reset, then width still zero
		add_row(ROW_SAMPLE, 32767, 1, 1, 0, 0);
		add_row(ROW_CFG, 63);
		add_row(ROW_SAMPLE, -32768);
		add_row(ROW_SAMPLE, 1, 1, 1, 0, 0);
		// width one: all-zero recording, then most negative sample alone
		add_row(ROW_CFG, 64);
		add_row(ROW_SAMPLE, 0);
		add_row(ROW_SAMPLE, 0, 1, 1, 0, 0);
		add_row(ROW_SAMPLE, -32768, 1, 1, 100, 0);
		// widest bins: everything lands in bin 0
		add_row(ROW_CFG, TOTAL_MAX);
		add_row(ROW_SAMPLE, 32767);
		add_row(ROW_SAMPLE, -32768);
		add_row(ROW_SAMPLE, -1, 1, 1, 100, 0);
		add_row(ROW_CFG, 130);
		add_row(ROW_SAMPLE, 1000);
		add_row(ROW_SAMPLE, -2000);
		add_row(ROW_SAMPLE, 500);
		add_row(ROW_SAMPLE, 7, 1);
		// width shrinks mid-recording below the current count
		add_row(ROW_CFG, 192);
		add_row(ROW_SAMPLE, 300);
		add_row(ROW_SAMPLE, -300);
		add_row(ROW_CFG, 64);
		add_row(ROW_SAMPLE, 100);
		add_row(ROW_SAMPLE, -150, 1);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				write_total(directed_rows[i].value);
			end else begin
				it.sample = web_pkg::SAMPLE_W'(directed_rows[i].value);
				it.end_of_recording = directed_rows[i].eor;
				send_sample(it, directed_rows[i].typed, directed_rows[i].pct_first,
					directed_rows[i].pct_rest);
			end
		end

		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 2) == 0) write_total(pick_total());
			r = $urandom_range(0, 99);
			if (r < 10) len = 1;
			else if (r < 70) len = $urandom_range(1, 40);
			else if (r < 90) len = $urandom_range(41, 80);
			else len = $urandom_range(100, 280);
			if (len > ITEM_TARGET - items_sent) len = ITEM_TARGET - items_sent;
			style = amp_style_t'($urandom_range(0, 7) > 3 ? STYLE_FULL : $urandom_range(0, 3));
			for (int i = 0; i < len; i++) begin
				if (i > 0 && $urandom_range(0, 39) == 0) write_total(pick_total());
				it.sample = pick_sample(style);
				it.end_of_recording = (i == len - 1);
				send_sample(it);
			end
		end

		push <= 1'b0;
		wait (bin_report_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && bin_report_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== waveform_envelope_binner.f =====
src/web_pkg.sv
src/web_front.sv
src/web_back.sv
src/waveform_envelope_binner.sv
sim/tb.sv
